// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms for the Q-table update engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk, masked while rst_n is low
`define QTUE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check on every rising edge of clk, reset included
`define QTUE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/qtue_pkg.sv =====
// ----------------------------------------------------------------------------
// qtue_pkg
// Widths, reset values, register indexes and sequencer states of the
// Q-table update engine.
// ----------------------------------------------------------------------------
package qtue_pkg;

  localparam int DEF_STATES     = 256;
  localparam int DEF_VALUE_BITS = 32;

  localparam int STATE_W   = 8;
  localparam int REWARD_W  = 32;
  localparam int OUT_VAL_W = 32;
  localparam int FACTOR_W  = 17;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 4;

  // Slice width of the shared multiplier
  localparam int MUL_CHUNK_W = 16;

  localparam logic [FACTOR_W-1:0] LEARNING_RATE_RST = 17'd45875;
  localparam logic [FACTOR_W-1:0] DISCOUNT_RST      = 17'd62915;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT      = 4'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_FETCH,
    ST_MUL_D,
    ST_TARGET,
    ST_DIFF,
    ST_MUL_L,
    ST_UPDATE,
    ST_WRITE
  } qtue_state_t;

endpackage

// ===== src/qtue_in_if.sv =====
// ----------------------------------------------------------------------------
// qtue_in_if
// Update request channel: present state, chosen action and reward.
// ----------------------------------------------------------------------------
interface qtue_in_if import qtue_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic [STATE_W-1:0]         present_state;
  logic [STATE_W-1:0]         chosen_action;
  logic signed [REWARD_W-1:0] reward;

  modport source (output valid, present_state, chosen_action, reward, input ready);
  modport sink   (input valid, present_state, chosen_action, reward, output ready);

endinterface

// ===== src/qtue_out_if.sv =====
// ----------------------------------------------------------------------------
// qtue_out_if
// Update result channel: new Q value and best entry of the next state.
// ----------------------------------------------------------------------------
interface qtue_out_if import qtue_pkg::*; ();

  logic                        valid;
  logic                        ready;
  logic signed [OUT_VAL_W-1:0] new_q_value;
  logic                        improved;
  logic [STATE_W-1:0]          next_best_action;
  logic signed [OUT_VAL_W-1:0] next_best_value;

  modport source (output valid, new_q_value, improved, next_best_action, next_best_value,
                  input ready);
  modport sink   (input valid, new_q_value, improved, next_best_action, next_best_value,
                  output ready);

endinterface

// ===== src/qtue_cfg_if.sv =====
// ----------------------------------------------------------------------------
// qtue_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface qtue_cfg_if import qtue_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FACTOR_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);

endinterface

// ===== src/qtue_ram.sv =====
// ----------------------------------------------------------------------------
// qtue_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module qtue_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/q_table_update_engine.sv =====
// ----------------------------------------------------------------------------
// q_table_update_engine
// Tabular Q-learning update with saturation and per-state best tracking.
// ----------------------------------------------------------------------------
// The block works on one request at a time: a request is taken only when idle,
// and the next one only after the previous result is loaded into the output
// register. Each update reads the Q and best-entry RAMs, which have registered
// read data; then one shared 17 x 18 bit multiplier forms the discount product
// and then the learning-rate product one 16-bit slice per cycle. A finished
// update holds until the output register is free. After reset a clearing pass
// zeroes all tables, during which no request is taken; register writes are
// taken at any time.
`include "assert_macros.svh"

module q_table_update_engine import qtue_pkg::*; #(
  parameter int STATES     = DEF_STATES,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic      clk,
  input logic      rst_n,
  qtue_in_if.sink  in_ch,
  qtue_out_if.source out_ch,
  qtue_cfg_if.sink cfg_ch
);

  localparam int VB     = VALUE_BITS;
  localparam int IW     = $clog2(STATES);
  localparam int QDEPTH = STATES * STATES;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int BW     = VB + STATE_W;
  localparam int TW     = ((VB + 1 > REWARD_W) ? VB + 1 : REWARD_W) + 1;
  localparam int DW     = TW + 1;
  localparam int NC     = (DW + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
  localparam int XW     = NC * MUL_CHUNK_W;
  localparam int PW     = MUL_CHUNK_W + FACTOR_W + 2;
  localparam int AW     = XW + FACTOR_W + 1;
  localparam int SUMW   = DW + 2;
  localparam int OW     = (VB > OUT_VAL_W) ? VB : OUT_VAL_W;
  localparam int CW     = (NC > 1) ? $clog2(NC) : 1;

  // Reduce an index modulo STATES by conditional subtraction, top weight first
  function automatic logic [STATE_W-1:0] reduce_idx(input logic [STATE_W-1:0] x);
    logic [STATE_W-1:0] r;
    r = x;
    for (int k = STATE_W - 1; k >= 0; k--) begin
      if (32'(r) >= (STATES << k)) begin
        r = r - STATE_W'(STATES << k);
      end
    end
    return r;
  endfunction

  qtue_state_t state_r, state_nxt;

  logic [QAW-1:0]            clr_cnt_r;
  logic [CW-1:0]             mul_cnt_r;
  logic                      out_valid_r;
  logic [FACTOR_W-1:0]       lr_r, disc_r;

  logic [IW-1:0]             s_idx_r, a_idx_r;
  logic signed [REWARD_W-1:0] reward_r;
  logic [QAW-1:0]            q_addr_r;
  logic signed [VB-1:0]      bv_a_r;
  logic [STATE_W-1:0]        ba_a_r;
  logic [XW-1:0]             mul_x_r;
  logic signed [AW-1:0]      acc_r;
  logic signed [TW-1:0]      target_r;
  logic signed [VB-1:0]      nq_r;

  logic signed [OUT_VAL_W-1:0] out_nq_r, out_nbv_r;
  logic                        out_imp_r;
  logic [STATE_W-1:0]          out_nba_r;

  // RAM ports
  logic           q_wr_en, q_rd_en;
  logic [QAW-1:0] q_wr_addr, q_rd_addr;
  logic [VB-1:0]  q_wr_data, q_rd_data;
  logic           b_wr_en, b_rd_en;
  logic [IW-1:0]  b_wr_addr, b_rd_addr;
  logic [BW-1:0]  b_wr_data, b_rd_data;

  logic in_ready, out_free, mul_last, clr_done, improved;
  logic [QAW-1:0] q_addr_c;

  assign out_free = !out_valid_r || out_ch.ready;
  assign mul_last = (mul_cnt_r == CW'(NC - 1));
  assign clr_done = (clr_cnt_r == QAW'(QDEPTH - 1));
  assign q_addr_c = QAW'(s_idx_r) * QAW'(STATES) + QAW'(a_idx_r);

  // Stored entries
  logic signed [VB-1:0] q_cur, bv_s;
  assign q_cur = $signed(q_rd_data);
  assign bv_s  = $signed(b_rd_data[BW-1:STATE_W]);
  assign improved = nq_r > bv_s;

  // Shared multiplier: one signed top slice, then unsigned lower slices
  logic [MUL_CHUNK_W-1:0]      chunk;
  logic signed [MUL_CHUNK_W:0] chunk_s;
  logic [FACTOR_W-1:0]         factor;
  logic signed [PW-1:0]        prod;
  logic signed [AW-1:0]        prod_ext, acc_base, acc_nxt;
  logic signed [AW-FRAC_W-1:0] acc_hi;

  assign chunk    = mul_x_r[XW-1 -: MUL_CHUNK_W];
  assign chunk_s  = (mul_cnt_r == '0) ? {chunk[MUL_CHUNK_W-1], chunk} : {1'b0, chunk};
  assign factor   = (state_r == ST_MUL_L) ? lr_r : disc_r;
  assign prod     = chunk_s * $signed({1'b0, factor});
  assign prod_ext = AW'(prod);
  assign acc_base = (mul_cnt_r == '0) ? AW'(0) : (acc_r <<< MUL_CHUNK_W);
  assign acc_nxt  = acc_base + prod_ext;
  assign acc_hi   = acc_r[AW-1:FRAC_W];

  // Target, difference and sum
  logic signed [TW-1:0]   md_t, rw_t;
  logic signed [DW-1:0]   tg_d, q_d, diff;
  logic signed [SUMW-1:0] ml_s, q_s, sum;
  logic signed [VB-1:0]   sat;
  logic                   fits;

  assign md_t = TW'(acc_hi);
  assign rw_t = TW'(reward_r);
  assign tg_d = DW'(target_r);
  assign q_d  = DW'(q_cur);
  assign diff = tg_d - q_d;
  assign ml_s = SUMW'(acc_hi);
  assign q_s  = SUMW'(q_cur);
  assign sum  = ml_s + q_s;
  assign fits = (&sum[SUMW-1:VB-1]) || !(|sum[SUMW-1:VB-1]);
  assign sat  = fits ? sum[VB-1:0] : {sum[SUMW-1], {(VB - 1){~sum[SUMW-1]}}};

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    q_wr_en   = 1'b0;
    q_wr_addr = q_addr_r;
    q_wr_data = nq_r;
    q_rd_en   = 1'b0;
    q_rd_addr = q_addr_c;
    b_wr_en   = 1'b0;
    b_wr_addr = s_idx_r;
    b_wr_data = {nq_r, STATE_W'(a_idx_r)};
    b_rd_en   = 1'b0;
    b_rd_addr = a_idx_r;
    case (state_r)
      ST_CLEAR: begin
        q_wr_en   = 1'b1;
        q_wr_addr = clr_cnt_r;
        q_wr_data = '0;
        b_wr_en   = (clr_cnt_r < QAW'(STATES));
        b_wr_addr = IW'(clr_cnt_r);
        b_wr_data = '0;
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        q_rd_en   = 1'b1;
        b_rd_en   = 1'b1;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        // best of the next state is in hand; fetch best of the present one
        b_rd_en   = 1'b1;
        b_rd_addr = s_idx_r;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        if (mul_last) begin
          state_nxt = ST_TARGET;
        end
      end
      ST_TARGET: state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_MUL_L;
      ST_MUL_L: begin
        if (mul_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_WRITE;
      ST_WRITE: begin
        // hold until the output register is free
        if (out_free) begin
          q_wr_en   = 1'b1;
          b_wr_en   = improved;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Control counters and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      mul_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + QAW'(1);
      end
      if (state_r == ST_FETCH || state_r == ST_DIFF) begin
        mul_cnt_r <= '0;
      end else if (state_r == ST_MUL_D || state_r == ST_MUL_L) begin
        mul_cnt_r <= mul_last ? '0 : mul_cnt_r + CW'(1);
      end
      if (state_r == ST_WRITE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= LEARNING_RATE_RST;
      disc_r <= DISCOUNT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_LEARNING_RATE: lr_r   <= cfg_ch.data;
        REG_DISCOUNT:      disc_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Datapath
  logic signed [OW-1:0] nq_ext, bv_a_ext;
  assign nq_ext   = OW'(nq_r);
  assign bv_a_ext = OW'(bv_a_r);

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          s_idx_r  <= IW'(reduce_idx(in_ch.present_state));
          a_idx_r  <= IW'(reduce_idx(in_ch.chosen_action));
          reward_r <= in_ch.reward;
        end
      end
      ST_ISSUE: q_addr_r <= q_addr_c;
      ST_FETCH: begin
        bv_a_r  <= $signed(b_rd_data[BW-1:STATE_W]);
        ba_a_r  <= b_rd_data[STATE_W-1:0];
        mul_x_r <= XW'($signed(b_rd_data[BW-1:STATE_W]));
      end
      ST_MUL_D, ST_MUL_L: begin
        acc_r   <= acc_nxt;
        mul_x_r <= mul_x_r << MUL_CHUNK_W;
      end
      ST_TARGET: target_r <= rw_t + md_t;
      ST_DIFF:   mul_x_r  <= XW'(diff);
      ST_UPDATE: nq_r     <= sat;
      ST_WRITE: begin
        if (out_free) begin
          out_nq_r  <= nq_ext[OUT_VAL_W-1:0];
          out_imp_r <= improved;
          // same state and action: report this update's best entry
          if (improved && s_idx_r == a_idx_r) begin
            out_nba_r <= STATE_W'(a_idx_r);
            out_nbv_r <= nq_ext[OUT_VAL_W-1:0];
          end else begin
            out_nba_r <= ba_a_r;
            out_nbv_r <= bv_a_ext[OUT_VAL_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready           = in_ready;
  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.new_q_value    = out_nq_r;
  assign out_ch.improved       = out_imp_r;
  assign out_ch.next_best_action = out_nba_r;
  assign out_ch.next_best_value  = out_nbv_r;

  qtue_ram #(
    .WIDTH (VB),
    .DEPTH (QDEPTH)
  ) u_q_ram (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (q_wr_addr),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data)
  );

  qtue_ram #(
    .WIDTH (BW),
    .DEPTH (STATES)
  ) u_best_ram (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (b_wr_data),
    .rd_en   (b_rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  `QTUE_ASSERT_RST(a_reset_clears, !rst_n |=> state_r == ST_CLEAR, "reset did not start clearing")
  `QTUE_ASSERT(a_result_from_write, $rose(out_valid_r) |-> $past(state_r) == ST_WRITE, "result loaded outside write step")
  `QTUE_ASSERT(a_mul_count, (state_r == ST_MUL_D || state_r == ST_MUL_L) |-> mul_cnt_r <= CW'(NC - 1), "multiplier slice count overran")
  `QTUE_ASSERT(a_self_best, $rose(out_valid_r) && out_imp_r && (s_idx_r == a_idx_r) |-> out_nbv_r == out_nq_r, "self transition best value mismatch")

endmodule

// ===== bench/q_update_check_pkg.sv =====
// ----------------------------------------------------------------------------
// q_update_check_pkg
// Predictor and result checker for the Q-table update engine: holds its own
// copy of the Q table, the best entries and the two factors, works out the
// result of each accepted request and compares the results as they arrive.
// ----------------------------------------------------------------------------
package q_update_check_pkg;
  import qtue_pkg::*;

  localparam longint VALUE_MAX = 64'sh7FFFFFFF;
  localparam longint VALUE_MIN = -64'sh80000000;

  typedef struct packed {
    logic signed [OUT_VAL_W-1:0] new_q_value;
    logic                        improved;
    logic [STATE_W-1:0]          next_best_action;
    logic signed [OUT_VAL_W-1:0] next_best_value;
  } q_update_t;

  class q_update_model;
    int                q_tab [DEF_STATES*DEF_STATES];
    int                best_val [DEF_STATES];
    bit [STATE_W-1:0]  best_act [DEF_STATES];
    bit [FACTOR_W-1:0] rate;
    bit [FACTOR_W-1:0] disc;
    q_update_t         pending_updates[$];
    int                errors;
    int                checked;
    int                improvements;
    int                saturations;

    function new();
      rate = LEARNING_RATE_RST;
      disc = DISCOUNT_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FACTOR_W-1:0] data);
      if (idx == REG_LEARNING_RATE) begin
        rate = data;
      end else if (idx == REG_DISCOUNT) begin
        disc = data;
      end
    endfunction

    // floor(x * f / 2^16); the product stays well inside 64 bits
    static function longint scale_q16(longint x, bit [FACTOR_W-1:0] f);
      longint fl;
      fl = f;
      return (x * fl) >>> FRAC_W;
    endfunction

    function void predict_update(bit [STATE_W-1:0] s, bit [STATE_W-1:0] a,
                                 bit signed [REWARD_W-1:0] r);
      longint    q;
      longint    target;
      longint    nq;
      int        idx;
      q_update_t u;
      idx    = {s, a};
      q      = q_tab[idx];
      target = longint'(r) + scale_q16(best_val[a], disc);
      nq     = q + scale_q16(target - q, rate);
      if (nq > VALUE_MAX) begin
        nq = VALUE_MAX;
        saturations++;
      end else if (nq < VALUE_MIN) begin
        nq = VALUE_MIN;
        saturations++;
      end
      q_tab[idx] = int'(nq);
      u.improved = (nq > best_val[s]);
      if (u.improved) begin
        best_val[s] = int'(nq);
        best_act[s] = a;
        improvements++;
      end
      // read the next state after the update: same state and action sees it
      u.new_q_value      = nq[OUT_VAL_W-1:0];
      u.next_best_action = best_act[a];
      u.next_best_value  = best_val[a];
      pending_updates.push_back(u);
    endfunction

    function void report(string field, logic [OUT_VAL_W-1:0] want, logic [OUT_VAL_W-1:0] got);
      $display("%0t: %s mismatch: expected %h actual %h", $time, field, want, got);
      errors++;
    endfunction

    function void check_update(q_update_t got);
      q_update_t want;
      if (pending_updates.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = pending_updates.pop_front();
      checked++;
      if (got.new_q_value !== want.new_q_value)
        report("new_q_value", want.new_q_value, got.new_q_value);
      if (got.improved !== want.improved)
        report("improved", want.improved, got.improved);
      if (got.next_best_action !== want.next_best_action)
        report("next_best_action", want.next_best_action, got.next_best_action);
      if (got.next_best_value !== want.next_best_value)
        report("next_best_value", want.next_best_value, got.next_best_value);
    endfunction

    function int outstanding();
      return pending_updates.size();
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives update requests and register writes into the Q-table update engine
// and checks every result against a predictor: a directed opening, a
// saturation burst, then random phases under several factor settings and
// idle patterns on both sides of the block.
// ----------------------------------------------------------------------------
module tb_top;
  import qtue_pkg::*;
  import q_update_check_pkg::*;

  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_REQUESTS = 215;
  localparam int SETTLE_CYCLES  = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   sender_idle_pct;
  int   receiver_stall_pct;

  q_update_model model;

  qtue_in_if  in_if ();
  qtue_out_if out_if ();
  qtue_cfg_if cfg_if ();

  q_table_update_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      model.check_update({out_if.new_q_value, out_if.improved,
                          out_if.next_best_action, out_if.next_best_value});
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, model.outstanding());
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_update(input logic [STATE_W-1:0] s, input logic [STATE_W-1:0] a,
                             input logic signed [REWARD_W-1:0] r);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.present_state <= s;
    in_if.chosen_action <= a;
    in_if.reward        <= r;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    model.predict_update(s, a, r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FACTOR_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    model.write_reg(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold requests back until every result is in, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (model.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly a small hot set of states so values build up and best entries move
  task automatic send_random(input logic [STATE_W-1:0] hot_base);
    logic [STATE_W-1:0]         s;
    logic [STATE_W-1:0]         a;
    logic signed [REWARD_W-1:0] r;
    int                         pick;
    pick = $urandom_range(99);
    s = hot_base + STATE_W'($urandom_range(7));
    a = hot_base + STATE_W'($urandom_range(7));
    r = $signed(32'($urandom_range(32'h40000))) - 32'sh20000;
    if (pick < 15) begin
      a = s;
    end else if (pick < 30) begin
      s = STATE_W'($urandom);
      a = STATE_W'($urandom);
      r = $urandom;
    end else if (pick < 40) begin
      case ($urandom_range(3))
        0: r = 32'sh7FFFFFFF;
        1: r = 32'sh80000000;
        2: r = $signed(32'($urandom_range(32'h7FFFFFFF, 32'h40000000)));
        default: r = -$signed(32'($urandom_range(32'h7FFFFFFF, 32'h40000000)));
      endcase
    end
    send_update(s, a, r);
  endtask

  initial begin
    logic [FACTOR_W-1:0] rate_plan [RANDOM_PHASES];
    logic [FACTOR_W-1:0] disc_plan [RANDOM_PHASES];
    int                  sender_plan [RANDOM_PHASES];
    int                  stall_plan [RANDOM_PHASES];
    logic [STATE_W-1:0]  hot_base;

    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.present_state = '0;
    in_if.chosen_action = '0;
    in_if.reward        = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_LEARNING_RATE;
    cfg_if.data         = '0;
    sender_idle_pct     = 0;
    receiver_stall_pct  = 0;
    model = new();

    rate_plan   = '{17'd65536, 17'd0, 17'h1FFFF, FACTOR_W'($urandom), LEARNING_RATE_RST,
                    17'd65536};
    disc_plan   = '{17'd65536, 17'd0, 17'h1FFFF, FACTOR_W'($urandom), DISCOUNT_RST, 17'd0};
    sender_plan = '{0, 78, 0, 28, 0, 78};
    stall_plan  = '{0, 0, 78, 28, 0, 0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset factors: corners of the indexes, reward extremes, same state and action
    send_update(8'd0,   8'd0,   32'sh00000000);
    send_update(8'd0,   8'd1,   32'sh00010000);
    send_update(8'd1,   8'd0,   32'sh7FFFFFFF);
    send_update(8'd2,   8'd3,   32'sh80000000);
    send_update(8'd255, 8'd255, 32'sh7FFFFFFF);
    send_update(8'd255, 8'd255, 32'sh7FFFFFFF);
    send_update(8'd255, 8'd0,   -32'sd1);
    send_update(8'd0,   8'd255, 32'sh12345678);
    send_update(8'd3,   8'd3,   32'sh80000000);
    send_update(8'd3,   8'd3,   32'sh80000000);
    send_update(8'd1,   8'd2,   32'sh00008000);
    send_update(8'd2,   8'd1,   -32'sh00008000);
    send_update(8'hAA,  8'h55,  32'sh55555555);
    send_update(8'h55,  8'hAA,  32'shAAAAAAAA);
    send_update(8'd1,   8'd1,   32'sd1);
    settle();

    // Factors near 2.0 push the update past both ends of the range
    write_reg(REG_LEARNING_RATE, 17'h1FFFF);
    write_reg(REG_DISCOUNT, 17'h1FFFF);
    send_update(8'd10, 8'd11, 32'sh7FFFFFFF);
    send_update(8'd10, 8'd11, 32'sh7FFFFFFF);
    send_update(8'd12, 8'd12, 32'sh80000000);
    send_update(8'd12, 8'd12, 32'sh80000000);
    send_update(8'd10, 8'd11, 32'sh80000000);
    send_update(8'd11, 8'd10, 32'sh7FFFFFFF);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 3) begin
        write_reg(REG_SPARE, FACTOR_W'($urandom));
      end
      write_reg(REG_LEARNING_RATE, rate_plan[p]);
      write_reg(REG_DISCOUNT, disc_plan[p]);
      sender_idle_pct    = sender_plan[p];
      receiver_stall_pct = stall_plan[p];
      hot_base = STATE_W'($urandom);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        send_random(hot_base);
        if ($urandom_range(149) == 0) begin
          settle();
        end
      end
      settle();
    end

    $display("Checked %0d updates over %0d factor phases and four idle patterns;",
             model.checked, RANDOM_PHASES + 2);
    $display("%0d raised a best entry and %0d saturated the Q value.",
             model.improvements, model.saturations);
    if (model.errors == 0 && model.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", model.errors, model.outstanding());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/qtue_pkg.sv
src/qtue_in_if.sv
src/qtue_out_if.sv
src/qtue_cfg_if.sv
src/qtue_ram.sv
src/q_table_update_engine.sv
bench/q_update_check_pkg.sv
bench/tb_top.sv
